// ===== rtl/core/next_permutation_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Next permutation generator - assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEXT_PERMUTATION_GENERATOR_DEFINES_SVH
`define NEXT_PERMUTATION_GENERATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NPG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/npg_pkg.sv =====
// ----------------------------------------------------------------------------
// npg_pkg
// Shared constants and types of the next permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package npg_pkg;

	// Width of the element fields on the channels.
	localparam int FIELD_W = 8;

	// Defaults for the top level parameters.
	localparam int MAX_LEN_DEF    = 16;
	localparam int ELEM_WIDTH_DEF = 8;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_CHECK,
		ST_FIND,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/npg_in_if.sv =====
// ----------------------------------------------------------------------------
// npg_in_if
// Load channel: one sequence element per item, last_in closes the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

interface npg_in_if;
	logic                        valid;
	logic                        ready;
	logic [npg_pkg::FIELD_W-1:0] elem_in;
	logic                        last_in;

	modport source (output valid, output elem_in, output last_in, input ready);
	modport sink   (input valid, input elem_in, input last_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/npg_out_if.sv =====
// ----------------------------------------------------------------------------
// npg_out_if
// Result channel: one element of the next permutation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface npg_out_if;
	logic                        valid;
	logic                        ready;
	logic [npg_pkg::FIELD_W-1:0] elem_out;
	logic                        last_out;
	logic                        no_successor;

	modport source (output valid, output elem_out, output last_out, output no_successor,
		input ready);
	modport sink   (input valid, input elem_out, input last_out, input no_successor,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/npg_ram.sv =====
// ----------------------------------------------------------------------------
// npg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/next_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// next_permutation_generator
// Loads a sequence item by item and streams out its lexicographic successor.
// ----------------------------------------------------------------------------
// Usage:
//   load   : one element per item (elem_in), last_in = 1 on the final one.
//            Elements past MAX_LEN are dropped; a dropped last_in still closes.
//   result : n items, elem_out in order, last_out on the final one,
//            no_successor = 1 on all of them when the input had no ascent
//            (then the sequence comes out unchanged).
// Steps for a sequence of n elements (pivot at position p):
//   load      one element per cycle while load.valid is high
//   scan      one element read per cycle through the RAM port
//   check     goes on to find when an ascent was seen, to emit otherwise
//   find      reads the positions after p when an ascent exists, skipped otherwise
//   emit      first result in the cycle after emit starts, then one per cycle
//             while the receiver does not stall
//   All steps share the single RAM read port; scan and find share one
//   comparator.
// load.ready is high only between sequences. A stalled result holds its item
// and the RAM read data; emission resumes when ready returns.
// Reset (arst_n low) drops any partial sequence and returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module next_permutation_generator #(
	parameter int MAX_LEN    = npg_pkg::MAX_LEN_DEF,
	parameter int ELEM_WIDTH = npg_pkg::ELEM_WIDTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	npg_in_if.sink     load,
	npg_out_if.source  result
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // store index
	localparam int CW = $clog2(MAX_LEN + 1);                 // element count
	localparam int FW = npg_pkg::FIELD_W;

	npg_pkg::state_t state_q, state_d;

	// control
	logic [CW-1:0] count_q;       // elements held
	logic [CW-1:0] ptr_q;         // next address to read (scan, find, emit)
	logic          dv_s1;         // RAM read data belongs to a sweep
	logic          found_q;       // an ascent was seen
	logic          out_valid_q;

	// payload
	logic [AW-1:0]         idx_s1;      // address of the data now on rdata
	logic [ELEM_WIDTH-1:0] prev_q;      // element left of idx_s1 during scan
	logic [AW-1:0]         pivot_q;
	logic [ELEM_WIDTH-1:0] pivot_val_q;
	logic [AW-1:0]         upper_q;
	logic [ELEM_WIDTH-1:0] upper_val_q;
	logic                  sub_q;       // emitted element comes from the swap
	logic [ELEM_WIDTH-1:0] sub_val_q;
	logic                  last_q;

	// RAM port
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ELEM_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [ELEM_WIDTH-1:0] ram_rdata;

	// shared comparator and sequencing strobes
	logic [ELEM_WIDTH-1:0] cmp_lhs;
	logic                  cmp_lt;
	logic                  sweep_issue;
	logic                  emit_issue;
	logic                  emit_take;

	// emit address mapping
	logic [AW-1:0]         ptr_a;
	logic [CW-1:0]         mirror;
	logic [AW-1:0]         mirror_a;
	logic [AW-1:0]         emit_addr;
	logic                  emit_sub;
	logic [ELEM_WIDTH-1:0] emit_sub_val;

	npg_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = ELEM_WIDTH'(load.elem_in);

	// One less-than serves both sweeps:
	//   scan: prev < cur marks an ascent
	//   find: pivot value < cur marks a swap candidate
	assign cmp_lhs = (state_q == npg_pkg::ST_SCAN) ? prev_q : pivot_val_q;
	assign cmp_lt  = cmp_lhs < ram_rdata;

	assign emit_take = out_valid_q && result.ready;

	// Output position i is read in place up to the pivot; past the pivot the
	// suffix is reversed, so position i reads index n + p - i. The pivot slot
	// shows the upper value and the upper slot shows the pivot value.
	assign ptr_a    = ptr_q[AW-1:0];
	assign mirror   = count_q + CW'(pivot_q) - ptr_q;
	assign mirror_a = mirror[AW-1:0];

	always_comb begin
		emit_addr    = ptr_a;
		emit_sub     = 1'b0;
		emit_sub_val = pivot_val_q;
		if (!found_q || (ptr_a < pivot_q)) begin
			emit_addr = ptr_a;
		end else if (ptr_a == pivot_q) begin
			emit_sub     = 1'b1;
			emit_sub_val = upper_val_q;
		end else begin
			emit_addr = mirror_a;
			emit_sub  = (mirror_a == upper_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npg_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		load.ready  = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = ptr_a;
		sweep_issue = 1'b0;
		emit_issue  = 1'b0;
		case (state_q)
			npg_pkg::ST_LOAD: begin
				load.ready = 1'b1;
				if (load.valid) begin
					// overflow elements are dropped
					ram_we = (count_q < CW'(MAX_LEN));
					if (load.last_in) begin
						state_d = npg_pkg::ST_SCAN;
					end
				end
			end
			npg_pkg::ST_SCAN, npg_pkg::ST_FIND: begin
				if (ptr_q < count_q) begin
					ram_re      = 1'b1;
					sweep_issue = 1'b1;
				end else if (state_q == npg_pkg::ST_SCAN) begin
					state_d = npg_pkg::ST_CHECK;
				end else begin
					state_d = npg_pkg::ST_EMIT;
				end
			end
			npg_pkg::ST_CHECK: begin
				state_d = found_q ? npg_pkg::ST_FIND : npg_pkg::ST_EMIT;
			end
			npg_pkg::ST_EMIT: begin
				if ((ptr_q < count_q) && (!out_valid_q || result.ready)) begin
					ram_re     = 1'b1;
					ram_raddr  = emit_addr;
					emit_issue = 1'b1;
				end else if (emit_take && last_q) begin
					state_d = npg_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = npg_pkg::ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			dv_s1       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dv_s1 <= sweep_issue;
			case (state_q)
				npg_pkg::ST_LOAD: begin
					if (ram_we) begin
						count_q <= count_q + CW'(1);
					end
					if (load.valid && load.last_in) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
					end
				end
				npg_pkg::ST_SCAN: begin
					if (sweep_issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (dv_s1 && (idx_s1 != '0) && cmp_lt) begin
						found_q <= 1'b1;
					end
				end
				npg_pkg::ST_CHECK: begin
					ptr_q <= found_q ? (CW'(pivot_q) + CW'(1)) : '0;
				end
				npg_pkg::ST_FIND: begin
					ptr_q <= sweep_issue ? (ptr_q + CW'(1)) : '0;
				end
				npg_pkg::ST_EMIT: begin
					if (emit_issue) begin
						ptr_q       <= ptr_q + CW'(1);
						out_valid_q <= 1'b1;
					end else if (emit_take) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							count_q <= '0;
						end
					end
				end
				default: begin
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sweep_issue) begin
			idx_s1 <= ptr_a;
		end
		if ((state_q == npg_pkg::ST_SCAN) && dv_s1) begin
			prev_q <= ram_rdata;
			// last ascent wins
			if ((idx_s1 != '0) && cmp_lt) begin
				pivot_q     <= AW'(idx_s1 - AW'(1));
				pivot_val_q <= prev_q;
			end
		end
		// last later element above the pivot wins
		if ((state_q == npg_pkg::ST_FIND) && dv_s1 && cmp_lt) begin
			upper_q     <= idx_s1;
			upper_val_q <= ram_rdata;
		end
		if (emit_issue) begin
			sub_q     <= emit_sub;
			sub_val_q <= emit_sub_val;
			last_q    <= ((ptr_q + CW'(1)) == count_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.elem_out     = FW'(sub_q ? sub_val_q : ram_rdata);
	assign result.last_out     = last_q;
	assign result.no_successor = !found_q;

endmodule

`default_nettype wire

// ===== rtl/core/npg_checker.sv =====
// ----------------------------------------------------------------------------
// npg_checker
// Port-level checks of the next permutation generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "next_permutation_generator_defines.svh"

module npg_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        load_valid,
	input wire logic                        load_ready,
	input wire logic                        load_last_in,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire logic [npg_pkg::FIELD_W-1:0] result_elem_out,
	input wire logic                        result_last_out,
	input wire logic                        result_no_successor
);

	// no new sequence is taken while results are pending
	`NPG_ASSERT_SAME(a_no_load_during_emit, result_valid, !load_ready, "load open during emit")

	`NPG_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result_elem_out) && $stable(result_last_out), "stalled item changed")

	// closing item starts the computation
	`NPG_ASSERT_NEXT(a_close_busy, load_valid && load_ready && load_last_in, !load_ready, "load open after close")

	// after the final result the block is back to loading
	`NPG_ASSERT_NEXT(a_end_of_run, result_valid && result_ready && result_last_out, !result_valid && load_ready, "no return to load")

	// wrap flag is the same on every item of one permutation
	`NPG_ASSERT_NEXT(a_flag_steady, result_valid && result_ready && !result_last_out, result_no_successor == $past(result_no_successor), "wrap flag changed")

endmodule

bind next_permutation_generator npg_checker u_npg_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.load_valid          (load.valid),
	.load_ready          (load.ready),
	.load_last_in        (load.last_in),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_elem_out     (result.elem_out),
	.result_last_out     (result.last_out),
	.result_no_successor (result.no_successor)
);

`default_nettype wire
